// File: rtl/utrb_pkg.sv
package utrb_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned BYTE_W          = 8;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TX_EMPTY = 2'd1,
        OP_RX_BYTE  = 2'd2,
        OP_READ     = 2'd3
    } opcode_t;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming transaction
        logic exec;    // update rings, issue store reads
        logic finish;  // load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_stall;  // result register full and not being taken
    } dp_stat_t;

endpackage

// File: rtl/utrb_cmd_if.sv
interface utrb_cmd_if;
    logic              valid;
    logic              ready;
    utrb_pkg::opcode_t opcode;
    utrb_pkg::byte_t   data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// File: rtl/utrb_rsp_if.sv
interface utrb_rsp_if;
    logic            valid;
    logic            ready;
    logic            send_valid;
    utrb_pkg::byte_t send_byte;
    logic            write_full;
    utrb_pkg::byte_t read_byte;
    logic            read_empty;
    logic            busy_sending;

    modport source (output valid, output send_valid, output send_byte,
                    output write_full, output read_byte, output read_empty,
                    output busy_sending, input ready);
    modport sink   (input valid, input send_valid, input send_byte,
                    input write_full, input read_byte, input read_empty,
                    input busy_sending, output ready);
endinterface

// File: rtl/utrb_ctrl.sv
module utrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  utrb_pkg::dp_stat_t stat,
    output utrb_pkg::dp_cmd_t  ctl
);
    import utrb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the previous result has been taken
                if (!stat.out_stall)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/utrb_datapath.sv
module utrb_datapath #(
    parameter int unsigned QUEUE_DEPTH = utrb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  utrb_pkg::dp_cmd_t ctl,
    output utrb_pkg::dp_stat_t stat,
    utrb_cmd_if.sink          cmd,
    utrb_rsp_if.source        rsp
);
    import utrb_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [PTR_W-1:0] ptr_t;

    function automatic ptr_t ring_next(input ptr_t p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    byte_t send_mem [QUEUE_DEPTH];
    byte_t recv_mem [QUEUE_DEPTH];

    ptr_t send_head_reg, send_head_next;
    ptr_t send_tail_reg, send_tail_next;
    ptr_t recv_head_reg, recv_head_next;
    ptr_t recv_tail_reg, recv_tail_next;
    logic sending_reg, sending_next;
    logic out_valid_reg, out_valid_next;

    opcode_t op_reg;
    byte_t   byte_reg;
    byte_t   rd_send_reg;
    byte_t   rd_recv_reg;

    // per-event flags, held from exec to finish
    logic s_valid_reg, s_direct_reg, w_full_reg, r_valid_reg, r_empty_reg;
    logic s_valid_next, s_direct_next, w_full_next, r_valid_next, r_empty_next;
    logic send_we, recv_we;

    logic  o_send_valid_reg, o_write_full_reg, o_read_empty_reg, o_busy_reg;
    byte_t o_send_byte_reg, o_read_byte_reg;

    ptr_t snh, rnh;

    assign snh = ring_next(send_head_reg);
    assign rnh = ring_next(recv_head_reg);

    always_comb
    begin
        send_head_next = send_head_reg;
        send_tail_next = send_tail_reg;
        recv_head_next = recv_head_reg;
        recv_tail_next = recv_tail_reg;
        sending_next   = sending_reg;
        s_valid_next   = 1'b0;
        s_direct_next  = 1'b0;
        w_full_next    = 1'b0;
        r_valid_next   = 1'b0;
        r_empty_next   = 1'b0;
        send_we        = 1'b0;
        recv_we        = 1'b0;
        case (op_reg)
            OP_WRITE:
            begin
                if (!sending_reg)
                begin
                    s_valid_next  = 1'b1;
                    s_direct_next = 1'b1;
                    sending_next  = 1'b1;
                end
                else if (snh != send_tail_reg)
                begin
                    send_we        = 1'b1;
                    send_head_next = snh;
                end
                else
                begin
                    w_full_next = 1'b1;
                end
            end
            OP_TX_EMPTY:
            begin
                if (send_head_reg == send_tail_reg)
                begin
                    sending_next = 1'b0;
                end
                else
                begin
                    s_valid_next   = 1'b1;
                    send_tail_next = ring_next(send_tail_reg);
                end
            end
            OP_RX_BYTE:
            begin
                // overwrite on full: drop the oldest byte
                recv_we        = 1'b1;
                recv_head_next = rnh;
                if (rnh == recv_tail_reg)
                    recv_tail_next = ring_next(recv_tail_reg);
            end
            OP_READ:
            begin
                if (recv_head_reg != recv_tail_reg)
                begin
                    r_valid_next   = 1'b1;
                    recv_tail_next = ring_next(recv_tail_reg);
                end
                else
                begin
                    r_empty_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (ctl.finish)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_head_reg <= '0;
            send_tail_reg <= '0;
            recv_head_reg <= '0;
            recv_tail_reg <= '0;
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                send_head_reg <= send_head_next;
                send_tail_reg <= send_tail_next;
                recv_head_reg <= recv_head_next;
                recv_tail_reg <= recv_tail_next;
                sending_reg   <= sending_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // stores and payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= cmd.opcode;
            byte_reg <= cmd.data_byte;
        end
        if (ctl.exec)
        begin
            if (send_we)
                send_mem[send_head_reg] <= byte_reg;
            if (recv_we)
                recv_mem[recv_head_reg] <= byte_reg;
            rd_send_reg  <= send_mem[send_tail_reg];
            rd_recv_reg  <= recv_mem[recv_tail_reg];
            s_valid_reg  <= s_valid_next;
            s_direct_reg <= s_direct_next;
            w_full_reg   <= w_full_next;
            r_valid_reg  <= r_valid_next;
            r_empty_reg  <= r_empty_next;
        end
        if (ctl.finish)
        begin
            o_send_valid_reg <= s_valid_reg;
            o_send_byte_reg  <= !s_valid_reg ? '0 : (s_direct_reg ? byte_reg : rd_send_reg);
            o_write_full_reg <= w_full_reg;
            o_read_byte_reg  <= r_valid_reg ? rd_recv_reg : '0;
            o_read_empty_reg <= r_empty_reg;
            o_busy_reg       <= sending_reg;
        end
    end

    assign stat.out_stall   = out_valid_reg && !rsp.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.send_valid   = o_send_valid_reg;
    assign rsp.send_byte    = o_send_byte_reg;
    assign rsp.write_full   = o_write_full_reg;
    assign rsp.read_byte    = o_read_byte_reg;
    assign rsp.read_empty   = o_read_empty_reg;
    assign rsp.busy_sending = o_busy_reg;

endmodule

// File: rtl/uart_tx_rx_ring_buffers.sv
// Channel | Role   | Payload                                           | Transfer
// --------+--------+---------------------------------------------------+---------------
// cmd     | sink   | opcode, data_byte                                 | valid && ready
// rsp     | source | send_valid, send_byte, write_full, read_byte,     | valid && ready
//         |        | read_empty, busy_sending                          |
//
// Each transaction passes through three steps: accept, ring update with store read,
// result load. The read port of each ring store is registered.
// A new transaction is accepted as soon as the result is loaded, while that
// result may still wait on rsp; a stalled rsp holds the block in its last step.
// Reset (rst_n, async, active low) clears pointers, transmit state and the
// result valid; ring contents are left undefined, no clearing pass.
module uart_tx_rx_ring_buffers #(
    parameter int unsigned QUEUE_DEPTH = utrb_pkg::QUEUE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    utrb_cmd_if.sink   cmd,
    utrb_rsp_if.source rsp
);
    import utrb_pkg::*;

    // command and status between sequencer and rings
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequencer: idle -> exec -> finish, one transaction at a time.
    utrb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd.valid),
        .item_ready (cmd.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    // Datapath: both rings (each keeps one slot free), the transmit state
    // flag and the result register.
    utrb_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule

// File: rtl/utrb_checker.sv
module utrb_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  send_valid,
    input logic [7:0]            send_byte,
    input logic                  write_full,
    input logic [7:0]            read_byte,
    input logic                  read_empty,
    input logic                  busy_sending
);

    // one transaction at a time: no accept straight after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("cmd accepted on consecutive cycles");

    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !send_valid) |-> (send_byte == 8'd0))
        else $error("send_byte non-zero without send_valid");

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && write_full) |-> (busy_sending && !send_valid && !read_empty))
        else $error("write_full with inconsistent flags");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && read_empty) |-> (read_byte == 8'd0 && !send_valid))
        else $error("read_empty with data or send");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(send_byte)
                                       && $stable(read_byte)))
        else $error("stalled rsp changed");

endmodule

bind uart_tx_rx_ring_buffers utrb_checker u_utrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .send_valid   (rsp.send_valid),
    .send_byte    (rsp.send_byte),
    .write_full   (rsp.write_full),
    .read_byte    (rsp.read_byte),
    .read_empty   (rsp.read_empty),
    .busy_sending (rsp.busy_sending)
);
